FILE: sv/mrrc_pkg.sv
// Types and constants shared by the mixed-radix range cursor and its checker.
`timescale 1ns / 1ps
`default_nettype none
package mrrc_pkg;

  localparam int DATA_W      = 64;
  localparam int DIGIT_W     = 16;
  localparam int NUM_RADIX   = 6;
  localparam int CNT_W       = 6;
  localparam int STATUS_W    = 3;
  localparam int DCOUNT_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int OUT_TDATA_W = NUM_RADIX * DIGIT_W;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_WINDOW = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_0     = 3'd1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_STEP = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_CHK1 = 7'b0001000,
    S_CHK2 = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

FILE: sv/mixed_radix_range_cursor.sv
// Mixed-radix odometer with windowed start and carry stepping over one shared adder.
// A step item passes through accept, step and result states.
// A start item runs a shift-add product over the digits in use, the window checks,
// a restoring division per digit (one quotient bit per cycle), and then the result.
// Throughput: one item at a time; the next item is accepted after the result is taken.
// Reset: synchronous active-low rst_n clears control state, no window, config to reset values.
`timescale 1ns / 1ps
`default_nettype none
module mixed_radix_range_cursor
  import mrrc_pkg::*;
#(
  parameter int MAX_DIGITS = 6,
  parameter int RADIX_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // offset[63:0], count[127:64]
  input  wire logic [0:0]             in_tuser,   // command[0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // digit_0[15:0] .. digit_5[95:80]
  output logic [STATUS_W-1:0]         out_tuser,  // status[2:0]
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int RB    = (RADIX_BITS < DIGIT_W) ? RADIX_BITS : DIGIT_W;
  localparam int RB_IW = $clog2(RB);
  localparam logic [DCOUNT_W-1:0] MAXD = DCOUNT_W'(MAX_DIGITS);

  state_t state_r, state_nxt;
  logic [DCOUNT_W-1:0] digit_count_r, digit_count_nxt;
  logic [DIGIT_W-1:0]  radix_r [NUM_RADIX];
  logic [DIGIT_W-1:0]  radix_nxt [NUM_RADIX];
  logic [RB-1:0]       pos_r [MAX_DIGITS];
  logic [RB-1:0]       pos_nxt [MAX_DIGITS];
  logic [DATA_W-1:0]   off_r, off_nxt;
  logic [DATA_W-1:0]   remaining_r, remaining_nxt;
  logic [DATA_W-1:0]   prod_r, prod_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic [RB-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DCOUNT_W-1:0] dig_r, dig_nxt;
  logic                ovf_r, ovf_nxt;
  logic                active_r, active_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                show_r, show_nxt;

  logic [DCOUNT_W-1:0] n_use;
  logic [RB-1:0]       r_cur;
  logic [RB:0]         rem_sh;
  logic [DATA_W-1:0]   add_a, add_b;
  logic                add_cin;
  logic [DATA_W:0]     sum;
  logic                ovf_now;
  logic [RB-1:0]       rem_new;
  logic [RB-1:0]       inc [MAX_DIGITS];
  logic                inc_ok [MAX_DIGITS];
  logic [RB-1:0]       step_pos [MAX_DIGITS];
  logic                step_carry;
  logic [CFG_IDX_W-1:0] radix_idx;

  always_comb begin
    if (digit_count_r == '0) begin
      n_use = DCOUNT_W'(1);
    end else if (digit_count_r > MAXD) begin
      n_use = MAXD;
    end else begin
      n_use = digit_count_r;
    end
  end

  assign r_cur   = radix_r[dig_r][RB-1:0];
  assign rem_sh  = {rem_r, off_r[DATA_W-1]};

  // The one adder: shift-add product, window checks, division and decrement.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (state_r)
      S_MUL: begin
        add_a = {acc_r[DATA_W-2:0], 1'b0};
        add_b = r_cur[cnt_r[RB_IW-1:0]] ? prod_r : '0;
      end
      S_CHK1: begin
        add_a   = prod_r;
        add_b   = ~off_r;
        add_cin = 1'b1;
      end
      S_CHK2: begin
        add_a   = acc_r;
        add_b   = ~remaining_r;
        add_cin = 1'b1;
      end
      S_DIV: begin
        add_a   = DATA_W'(rem_sh);
        add_b   = ~DATA_W'(r_cur);
        add_cin = 1'b1;
      end
      S_STEP: begin
        add_a = remaining_r;
        add_b = '1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign sum     = {1'b0, add_a} + {1'b0, add_b} + (DATA_W + 1)'(add_cin);
  assign ovf_now = ovf_r | acc_r[DATA_W-1] | sum[DATA_W];
  assign rem_new = sum[DATA_W] ? sum[RB-1:0] : rem_sh[RB-1:0];

  always_comb begin
    logic found;
    found = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      inc[i]      = pos_r[i] + 1'b1;
      inc_ok[i]   = (inc[i] != '0) && (inc[i] < radix_r[i][RB-1:0])
                    && (DCOUNT_W'(i) < n_use);
      step_pos[i] = pos_r[i];
      if (!found) begin
        if (inc_ok[i]) begin
          step_pos[i] = inc[i];
          found       = 1'b1;
        end else if (DCOUNT_W'(i) < n_use) begin
          step_pos[i] = '0;
        end
      end
    end
    step_carry = !found;
  end

  assign radix_idx = cfg_index - REG_RADIX_0;

  always_comb begin
    state_nxt       = state_r;
    digit_count_nxt = digit_count_r;
    radix_nxt       = radix_r;
    pos_nxt         = pos_r;
    off_nxt         = off_r;
    remaining_nxt   = remaining_r;
    prod_nxt        = prod_r;
    acc_nxt         = acc_r;
    rem_nxt         = rem_r;
    cnt_nxt         = cnt_r;
    dig_nxt         = dig_r;
    ovf_nxt         = ovf_r;
    active_nxt      = active_r;
    status_nxt      = status_r;
    show_nxt        = show_r;

    if (cfg_we) begin
      if (cfg_index == REG_DIGIT_COUNT) begin
        digit_count_nxt = cfg_data[DCOUNT_W-1:0];
      end else if (cfg_index >= REG_RADIX_0 && radix_idx < CFG_IDX_W'(NUM_RADIX)) begin
        radix_nxt[radix_idx] = cfg_data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0] == CMD_STEP) begin
            state_nxt = S_STEP;
          end else begin
            off_nxt       = in_tdata[DATA_W-1:0];
            remaining_nxt = in_tdata[IN_TDATA_W-1:DATA_W];
            prod_nxt      = DATA_W'(1);
            acc_nxt       = '0;
            ovf_nxt       = 1'b0;
            dig_nxt       = '0;
            cnt_nxt       = CNT_W'(RB - 1);
            state_nxt     = S_MUL;
          end
        end
      end
      S_MUL: begin
        acc_nxt = sum[DATA_W-1:0];
        ovf_nxt = ovf_now;
        if (cnt_r == '0) begin
          if (ovf_now) begin
            status_nxt = ST_OVERFLOW;
            show_nxt   = 1'b0;
            active_nxt = 1'b0;
            state_nxt  = S_OUT;
          end else begin
            prod_nxt = sum[DATA_W-1:0];
            acc_nxt  = '0;
            ovf_nxt  = 1'b0;
            if (dig_r == n_use - DCOUNT_W'(1)) begin
              state_nxt = S_CHK1;
            end else begin
              dig_nxt = dig_r + DCOUNT_W'(1);
              cnt_nxt = CNT_W'(RB - 1);
            end
          end
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_CHK1: begin
        if (!sum[DATA_W] || sum[DATA_W-1:0] == '0 || remaining_r == '0) begin
          status_nxt = ST_REFUSED;
          show_nxt   = 1'b0;
          active_nxt = 1'b0;
          state_nxt  = S_OUT;
        end else begin
          acc_nxt   = sum[DATA_W-1:0];
          state_nxt = S_CHK2;
        end
      end
      S_CHK2: begin
        if (!sum[DATA_W]) begin
          status_nxt = ST_REFUSED;
          show_nxt   = 1'b0;
          active_nxt = 1'b0;
          state_nxt  = S_OUT;
        end else begin
          dig_nxt   = '0;
          cnt_nxt   = CNT_W'(DATA_W - 1);
          rem_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = rem_new;
        off_nxt = {off_r[DATA_W-2:0], sum[DATA_W]};
        if (cnt_r == '0) begin
          for (int i = 0; i < MAX_DIGITS; i++) begin
            if (DCOUNT_W'(i) == dig_r) begin
              pos_nxt[i] = rem_new;
            end else if (DCOUNT_W'(i) >= n_use) begin
              pos_nxt[i] = '0;
            end
          end
          rem_nxt = '0;
          if (dig_r == n_use - DCOUNT_W'(1)) begin
            active_nxt = 1'b1;
            status_nxt = ST_OK;
            show_nxt   = 1'b1;
            state_nxt  = S_OUT;
          end else begin
            dig_nxt = dig_r + DCOUNT_W'(1);
            cnt_nxt = CNT_W'(DATA_W - 1);
          end
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_STEP: begin
        show_nxt  = 1'b0;
        state_nxt = S_OUT;
        if (!active_r) begin
          status_nxt = ST_NO_WINDOW;
        end else if (remaining_r == '0) begin
          status_nxt = ST_EXHAUSTED;
        end else begin
          remaining_nxt = sum[DATA_W-1:0];
          if (sum[DATA_W-1:0] == '0) begin
            status_nxt = ST_EXHAUSTED;
          end else if (step_carry) begin
            pos_nxt       = step_pos;
            remaining_nxt = '0;
            status_nxt    = ST_EXHAUSTED;
          end else begin
            pos_nxt    = step_pos;
            status_nxt = ST_OK;
            show_nxt   = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      digit_count_r <= DCOUNT_W'(1);
      for (int i = 0; i < NUM_RADIX; i++) begin
        radix_r[i] <= DIGIT_W'(1);
      end
      for (int i = 0; i < MAX_DIGITS; i++) begin
        pos_r[i] <= '0;
      end
      remaining_r <= '0;
      active_r    <= 1'b0;
      status_r    <= ST_OK;
      show_r      <= 1'b0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      dig_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      digit_count_r <= digit_count_nxt;
      radix_r       <= radix_nxt;
      pos_r         <= pos_nxt;
      remaining_r   <= remaining_nxt;
      active_r      <= active_nxt;
      status_r      <= status_nxt;
      show_r        <= show_nxt;
      ovf_r         <= ovf_nxt;
      cnt_r         <= cnt_nxt;
      dig_r         <= dig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = status_r;

  for (genvar g = 0; g < NUM_RADIX; g++) begin : g_out
    if (g < MAX_DIGITS) begin : g_used
      assign out_tdata[g*DIGIT_W +: DIGIT_W] =
        (show_r && DCOUNT_W'(g) < n_use) ? DIGIT_W'(pos_r[g]) : '0;
    end else begin : g_unused
      assign out_tdata[g*DIGIT_W +: DIGIT_W] = '0;
    end
  end

endmodule
`default_nettype wire

FILE: sv/mrrc_checker.sv
// Port-level checker for the mixed-radix range cursor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mrrc_checker
  import mrrc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [STATUS_W-1:0]    out_tuser
);

  // An item is taken only when no result is waiting.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready right after an accepted item");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> !out_tvalid)
    else $error("more than one result for an item");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  // Digits are shown only with an ok status.
  a_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata == '0))
    else $error("digits shown with a non-ok status");

endmodule

bind mixed_radix_range_cursor mrrc_checker u_mrrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the mixed-radix range cursor: directed and random windows.
`timescale 1ns / 1ps
module tb;
  import mrrc_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int STALL_LIMIT = 6000;
  localparam int PRINT_LIMIT = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0]               status;
    logic [NUM_RADIX-1:0][DIGIT_W-1:0] digits;
  } cursor_result_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [0:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  logic [DCOUNT_W-1:0] shape_digits;
  logic [DIGIT_W-1:0]  shape_radix [NUM_RADIX];
  logic [DIGIT_W-1:0]  odo_pos [NUM_RADIX];
  logic [63:0]         odo_left;
  logic                odo_active;

  cursor_result_t pending_results[$];
  cursor_result_t want;
  int unsigned    items_sent    = 0;
  int unsigned    results_seen  = 0;
  int unsigned    fail_count    = 0;
  int unsigned    idle_cycles   = 0;
  int unsigned    burst_left    = 0;
  bit             gaps_on       = 1'b1;
  logic [31:0]    cycle_count   = '0;
  ready_mode_t    ready_mode    = RDY_ALWAYS;

  mixed_radix_range_cursor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned digits_in_use();
    if (shape_digits == '0) return 1;
    if (shape_digits > NUM_RADIX) return NUM_RADIX;
    return 32'(shape_digits);
  endfunction

  function automatic logic [63:0] radix_product(output logic overflow);
    logic [127:0] wide;
    logic [63:0]  prod;
    prod = 64'd1;
    overflow = 1'b0;
    for (int i = 0; i < digits_in_use(); i++) begin
      wide = {64'd0, prod} * {112'd0, shape_radix[i]};
      if (wide[127:64] != '0) overflow = 1'b1;
      else prod = wide[63:0];
    end
    return prod;
  endfunction

  function automatic cursor_result_t cursor_advance(logic cmd, logic [63:0] offset,
                                                   logic [63:0] count);
    cursor_result_t     res;
    int unsigned        n;
    logic               overflow;
    logic               carry;
    logic [63:0]        prod;
    logic [63:0]        quot;
    logic [63:0]        rem;
    logic [DIGIT_W-1:0] p;
    res = '0;
    n = digits_in_use();
    if (cmd == CMD_START) begin
      prod = radix_product(overflow);
      if (overflow) begin
        res.status = ST_OVERFLOW;
        odo_active = 1'b0;
      end else if (prod == '0 || count == '0 || offset >= prod || count > prod - offset) begin
        res.status = ST_REFUSED;
        odo_active = 1'b0;
      end else begin
        quot = offset;
        for (int i = 0; i < NUM_RADIX; i++) begin
          if (i < n) begin
            rem = quot % {48'd0, shape_radix[i]};
            quot = quot / {48'd0, shape_radix[i]};
            odo_pos[i] = rem[DIGIT_W-1:0];
          end else begin
            odo_pos[i] = '0;
          end
        end
        odo_left = count;
        odo_active = 1'b1;
        res.status = ST_OK;
      end
    end else if (!odo_active) begin
      res.status = ST_NO_WINDOW;
    end else if (odo_left <= 64'd1) begin
      odo_left = '0;
      res.status = ST_EXHAUSTED;
    end else begin
      odo_left = odo_left - 64'd1;
      carry = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (carry) begin
          p = odo_pos[i] + 16'd1;
          if (p != '0 && p < shape_radix[i]) begin
            odo_pos[i] = p;
            carry = 1'b0;
          end else begin
            odo_pos[i] = '0;
          end
        end
      end
      if (carry) begin
        odo_left = '0;
        res.status = ST_EXHAUSTED;
      end else begin
        res.status = ST_OK;
      end
    end
    if (res.status == ST_OK) begin
      for (int i = 0; i < n; i++) res.digits[i] = odo_pos[i];
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] expected_v);
    fail_count++;
    if (fail_count <= PRINT_LIMIT)
      $display("[%0t] error: result %0d %s got %0h, expected %0h",
               $time, results_seen, field, got, expected_v);
  endtask

  task automatic send_item(logic cmd, logic [63:0] offset, logic [63:0] count);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 12) : 0;
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {count, offset};
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), cursor_advance(cmd, offset, count));
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_DIGIT_COUNT) shape_digits = value[DCOUNT_W-1:0];
    else if (idx >= REG_RADIX_0 && idx < REG_RADIX_0 + NUM_RADIX)
      shape_radix[idx - REG_RADIX_0] = value;
  endtask

  task automatic set_shape(logic [CFG_DATA_W-1:0] n, logic [CFG_DATA_W-1:0] r0,
                           logic [CFG_DATA_W-1:0] r1, logic [CFG_DATA_W-1:0] r2,
                           logic [CFG_DATA_W-1:0] r3, logic [CFG_DATA_W-1:0] r4,
                           logic [CFG_DATA_W-1:0] r5);
    write_reg(REG_DIGIT_COUNT, n);
    write_reg(REG_RADIX_0, r0);
    write_reg(REG_RADIX_0 + 3'd1, r1);
    write_reg(REG_RADIX_0 + 3'd2, r2);
    write_reg(REG_RADIX_0 + 3'd3, r3);
    write_reg(REG_RADIX_0 + 3'd4, r4);
    write_reg(REG_RADIX_0 + 3'd5, r5);
  endtask

  task automatic test_no_window();
    send_item(CMD_STEP, 64'd0, 64'd0);
    send_item(CMD_STEP, rand64(), rand64());
    send_item(CMD_START, 64'd0, 64'd1);
    send_item(CMD_STEP, 64'd0, 64'd0);
    send_item(CMD_STEP, 64'd0, 64'd0);
  endtask

  task automatic test_window_bounds();
    wait_for_results();
    set_shape(16'd3, 16'd3, 16'd4, 16'd5, 16'd1, 16'd1, 16'd1);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_item(CMD_START, 64'd0, 64'd60);
    send_item(CMD_START, 64'd59, 64'd1);
    send_item(CMD_START, 64'd7, 64'd0);
    send_item(CMD_START, 64'd60, 64'd1);
    send_item(CMD_START, 64'd10, 64'd51);
    send_item(CMD_START, 64'd10, 64'd50);
    send_item(CMD_STEP, 64'd0, 64'd0);
    send_item(CMD_STEP, 64'd0, 64'd0);
    send_item(CMD_STEP, 64'd0, 64'd0);
  endtask

  task automatic test_extreme_radices();
    logic        overflow;
    logic [63:0] prod;
    wait_for_results();
    set_shape(16'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    prod = radix_product(overflow);
    send_item(CMD_START, prod - 64'd1, 64'd1);
    send_item(CMD_STEP, 64'd0, 64'd0);
    send_item(CMD_START, '1, '1);
    send_item(CMD_STEP, 64'd0, 64'd0);
    wait_for_results();
    write_reg(REG_DIGIT_COUNT, 16'd6);
    send_item(CMD_START, 64'd0, 64'd1);
    wait_for_results();
    write_reg(REG_DIGIT_COUNT, 16'd7);
    send_item(CMD_START, 64'd0, 64'd1);
    send_item(CMD_STEP, 64'd0, 64'd0);
    wait_for_results();
    write_reg(REG_DIGIT_COUNT, 16'd0);
    send_item(CMD_START, 64'd65534, 64'd1);
    wait_for_results();
    write_reg(REG_DIGIT_COUNT, 16'd6);
    write_reg(REG_RADIX_0, 16'd0);
    send_item(CMD_START, 64'd0, 64'd1);
  endtask

  task automatic test_live_radix_change();
    wait_for_results();
    set_shape(16'd2, 16'd3, 16'd3, 16'd1, 16'd1, 16'd1, 16'd1);
    send_item(CMD_START, 64'd5, 64'd4);
    wait_for_results();
    write_reg(REG_RADIX_0, 16'd2);
    write_reg(REG_RADIX_0 + 3'd1, 16'd1);
    send_item(CMD_STEP, 64'd0, 64'd0);
    send_item(CMD_STEP, 64'd0, 64'd0);
  endtask

  task automatic test_random_windows();
    logic                  overflow;
    logic [63:0]           prod;
    logic [63:0]           offset;
    logic [63:0]           count;
    logic [63:0]           span;
    logic [CFG_DATA_W-1:0] pick [NUM_RADIX];
    logic [CFG_DATA_W-1:0] n;
    int unsigned           style;
    int unsigned           kind;
    int unsigned           steps;
    while (items_sent < ITEM_TARGET) begin
      wait_for_results();
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 1) ? 16'd7 : 16'd0;
      else n = 16'($urandom_range(1, 6));
      style = $urandom_range(0, 9);
      for (int i = 0; i < NUM_RADIX; i++) begin
        if (style < 6) pick[i] = 16'($urandom_range(1, 6));
        else if (style < 8) pick[i] = 16'($urandom);
        else if (style == 8)
          pick[i] = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 9));
        else pick[i] = 16'hFFFF - 16'($urandom_range(0, 2));
      end
      set_shape(n, pick[0], pick[1], pick[2], pick[3], pick[4], pick[5]);
      gaps_on = ($urandom_range(0, 2) != 0);
      prod = radix_product(overflow);
      // Steps here continue a window opened under the previous register settings.
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 6)) send_item(CMD_STEP, rand64(), rand64());
      repeat ($urandom_range(1, 4)) begin
        kind = $urandom_range(0, 9);
        if (kind == 9) wait_for_results();
        if (overflow || prod == '0 || kind == 0) begin
          case ($urandom_range(0, 2))
            0: begin
              offset = rand64();
              count = rand64();
            end
            1: begin
              offset = 64'($urandom_range(0, 20));
              count = '0;
            end
            default: begin
              offset = prod + 64'($urandom_range(0, 3));
              count = 64'd1;
            end
          endcase
          send_item(CMD_START, offset, count);
          repeat ($urandom_range(0, 4)) send_item(CMD_STEP, rand64(), rand64());
        end else begin
          if ($urandom_range(0, 1) == 0) offset = rand64() % prod;
          else offset = prod - 64'd1 - ({32'd0, $urandom_range(0, 20)} % prod);
          span = prod - offset;
          if (span <= 64'd60) count = 64'($urandom_range(1, int'(span)));
          else if ($urandom_range(0, 4) != 0) count = 64'($urandom_range(1, 60));
          else count = rand64() % span + 64'd1;
          send_item(CMD_START, offset, count);
          steps = (count < 64'd48) ? int'(count) + $urandom_range(0, 2) : $urandom_range(8, 48);
          repeat (steps) send_item(CMD_STEP, rand64(), rand64());
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 32'd1;
    if (cycle_count[7:0] == 8'd0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:    out_tready <= (cycle_count[3:0] < 4'd11);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item waiting", {61'd0, out_tuser}, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", {61'd0, out_tuser}, {61'd0, want.status});
        for (int i = 0; i < NUM_RADIX; i++) begin
          if (out_tdata[i*DIGIT_W +: DIGIT_W] !== want.digits[i])
            report_mismatch($sformatf("digit_%0d", i), {48'd0, out_tdata[i*DIGIT_W +: DIGIT_W]},
                            {48'd0, want.digits[i]});
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("mixed_radix_range_cursor: mismatch");
      $finish;
    end
  end

  initial begin
    shape_digits = 3'd1;
    for (int i = 0; i < NUM_RADIX; i++) begin
      shape_radix[i] = 16'd1;
      odo_pos[i] = '0;
    end
    odo_left = '0;
    odo_active = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_no_window();
    test_window_bounds();
    test_extreme_radices();
    test_live_radix_change();
    test_random_windows();
    wait_for_results();
    repeat (16) @(posedge clk);
    if (fail_count == 0) $display("mixed_radix_range_cursor: match");
    else $display("mixed_radix_range_cursor: mismatch");
    $finish;
  end

endmodule
